@@ design/knob_adc_to_duty_limit_top_assert.svh @@
`ifndef KNOB_ADC_TO_DUTY_LIMIT_TOP_ASSERT_SVH
`define KNOB_ADC_TO_DUTY_LIMIT_TOP_ASSERT_SVH

// same-cycle implication
`define KADL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KADL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/kadl_pkg.sv @@
package kadl_pkg;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int REG_IW = 3;

    typedef enum logic [REG_IW-1:0] {
        REG_MIN_THR  = 3'd0,
        REG_THR_20   = 3'd1,
        REG_THR_40   = 3'd2,
        REG_THR_50   = 3'd3,
        REG_THR_60   = 3'd4,
        REG_TOP_THR  = 3'd5,
        REG_MAX_DUTY = 3'd6
    } t_reg_idx;

    localparam logic [31:0] RST_MIN_THR  = 32'd480;
    localparam logic [31:0] RST_THR_20   = 32'd1278;
    localparam logic [31:0] RST_THR_40   = 32'd2498;
    localparam logic [31:0] RST_THR_50   = 32'd2641;
    localparam logic [31:0] RST_THR_60   = 32'd3482;
    localparam logic [31:0] RST_TOP_THR  = 32'd4087;
    localparam logic [31:0] RST_MAX_DUTY = 32'd6000;

    // segment scale in tenths
    typedef logic [3:0] t_tenths;
    localparam t_tenths TENTHS_2 = 4'd2;
    localparam t_tenths TENTHS_4 = 4'd4;
    localparam t_tenths TENTHS_5 = 4'd5;
    localparam t_tenths TENTHS_6 = 4'd6;
    localparam t_tenths TENTHS_8 = 4'd8;

    // extra bits for a factor below 16 (tenths, and the 10 of the divisor)
    localparam int SCALE_BITS = 4;

endpackage

@@ design/kadl_if.sv @@
interface kadl_in_if #(
    parameter int ADC_BITS = 12
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface kadl_out_if #(
    parameter int DUTY_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] duty_limit;
    logic                 off_latched;

    modport source (output valid, output duty_limit, output off_latched, input ready);
    modport sink   (input valid, input duty_limit, input off_latched, output ready);
endinterface

@@ design/knob_adc_to_duty_limit_top.sv @@
// Channel    Dir  Payload                       Handshake
// in_ch      in   adc_sample                    valid/ready
// out_ch     out  duty_limit, off_latched       valid/ready
// apb        in   7 config regs at 4*index      psel/penable/pwrite, pready=1
//
// One item at a time. Latched, zero-band and full-duty samples go straight to S_DONE.
// Scaled segments pass S_MUL, S_SCALE, S_CHECK and S_DIV, using the bit-serial
// shift-add multiplier and the one-bit-per-cycle restoring divider;
// a saturating quotient or a zero divisor skips the divider.
// Reset (synchronous) loads the register defaults and clears the off latch.
// A result held by a stalled output stops the next result, not the next accept.
module knob_adc_to_duty_limit_top
    import kadl_pkg::*;
#(
    parameter int ADC_BITS  = 12,
    parameter int DUTY_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    kadl_in_if.sink              in_ch,
    kadl_out_if.source           out_ch,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [APB_AW-1:0]    i_paddr,
    input  logic [APB_DW-1:0]    i_pwdata,
    output logic [APB_DW-1:0]    o_prdata,
    output logic                 o_pready
);

    localparam int PW   = ADC_BITS + DUTY_BITS;
    localparam int DW   = PW + SCALE_BITS;
    localparam int HW   = ADC_BITS + SCALE_BITS;
    localparam int NMAX = (ADC_BITS > DUTY_BITS) ? ADC_BITS : DUTY_BITS;
    localparam int CW   = $clog2(NMAX + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_SCALE = 6'b000100,
        S_CHECK = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [ADC_BITS-1:0]   r_mplier, n_mplier;
    logic [PW-1:0]         r_mcand, n_mcand;
    logic [PW-1:0]         r_acc, n_acc;
    t_tenths               r_tenths, n_tenths;
    logic [HW-1:0]         r_den, n_den;
    logic [HW-1:0]         r_rem, n_rem;
    logic [DUTY_BITS-1:0]  r_quo, n_quo;
    logic [DUTY_BITS-1:0]  r_res_limit, n_res_limit;
    logic                  r_res_latch, n_res_latch;
    logic                  r_latch, n_latch;
    logic                  r_out_valid, n_out_valid;
    logic [DUTY_BITS-1:0]  r_out_limit, n_out_limit;
    logic                  r_out_latch, n_out_latch;

    logic [ADC_BITS-1:0]   r_thr [6];
    logic [DUTY_BITS-1:0]  r_max_duty;

    logic                  w_accept;
    logic [ADC_BITS-1:0]   w_s;
    logic                  w_go_mul;
    logic [ADC_BITS-1:0]   w_num;
    logic [ADC_BITS-1:0]   w_sel_thr;
    t_tenths               w_sel_tenths;
    logic [HW-1:0]         w_thr_ext;
    logic [DW-1:0]         w_acc_ext;
    logic [DW-1:0]         w_dividend;
    logic [HW:0]           w_rem2;
    logic                  w_ge;
    logic [DUTY_BITS-1:0]  w_qnext;
    logic                  w_cfg_wr;
    logic [REG_IW-1:0]     w_idx;

    assign in_ch.ready        = (r_state == S_IDLE);
    assign w_accept           = in_ch.valid && in_ch.ready;
    assign w_s                = in_ch.adc_sample;
    assign out_ch.valid       = r_out_valid;
    assign out_ch.duty_limit  = r_out_limit;
    assign out_ch.off_latched = r_out_latch;

    // configuration
    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite;
    assign w_idx    = i_paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr[REG_MIN_THR] <= RST_MIN_THR[ADC_BITS-1:0];
            r_thr[REG_THR_20]  <= RST_THR_20[ADC_BITS-1:0];
            r_thr[REG_THR_40]  <= RST_THR_40[ADC_BITS-1:0];
            r_thr[REG_THR_50]  <= RST_THR_50[ADC_BITS-1:0];
            r_thr[REG_THR_60]  <= RST_THR_60[ADC_BITS-1:0];
            r_thr[REG_TOP_THR] <= RST_TOP_THR[ADC_BITS-1:0];
            r_max_duty         <= RST_MAX_DUTY[DUTY_BITS-1:0];
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_MIN_THR:  r_thr[REG_MIN_THR] <= i_pwdata[ADC_BITS-1:0];
                REG_THR_20:   r_thr[REG_THR_20]  <= i_pwdata[ADC_BITS-1:0];
                REG_THR_40:   r_thr[REG_THR_40]  <= i_pwdata[ADC_BITS-1:0];
                REG_THR_50:   r_thr[REG_THR_50]  <= i_pwdata[ADC_BITS-1:0];
                REG_THR_60:   r_thr[REG_THR_60]  <= i_pwdata[ADC_BITS-1:0];
                REG_TOP_THR:  r_thr[REG_TOP_THR] <= i_pwdata[ADC_BITS-1:0];
                REG_MAX_DUTY: r_max_duty         <= i_pwdata[DUTY_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        unique case (w_idx)
            REG_MIN_THR:  o_prdata = APB_DW'(r_thr[REG_MIN_THR]);
            REG_THR_20:   o_prdata = APB_DW'(r_thr[REG_THR_20]);
            REG_THR_40:   o_prdata = APB_DW'(r_thr[REG_THR_40]);
            REG_THR_50:   o_prdata = APB_DW'(r_thr[REG_THR_50]);
            REG_THR_60:   o_prdata = APB_DW'(r_thr[REG_THR_60]);
            REG_TOP_THR:  o_prdata = APB_DW'(r_thr[REG_TOP_THR]);
            REG_MAX_DUTY: o_prdata = APB_DW'(r_max_duty);
            default:      o_prdata = '0;
        endcase
    end

    // segment select; thresholds checked in list order
    always_comb begin
        w_go_mul     = 1'b1;
        w_num        = w_s;
        w_sel_thr    = r_thr[REG_TOP_THR];
        w_sel_tenths = TENTHS_8;
        if (w_s <= r_thr[REG_MIN_THR]) begin
            w_go_mul = 1'b0;
        end else if (w_s <= r_thr[REG_THR_20]) begin
            w_num        = w_s - r_thr[REG_MIN_THR];
            w_sel_thr    = r_thr[REG_THR_20];
            w_sel_tenths = TENTHS_2;
        end else if (w_s <= r_thr[REG_THR_40]) begin
            w_sel_thr    = r_thr[REG_THR_40];
            w_sel_tenths = TENTHS_4;
        end else if (w_s <= r_thr[REG_THR_50]) begin
            w_sel_thr    = r_thr[REG_THR_50];
            w_sel_tenths = TENTHS_5;
        end else if (w_s <= r_thr[REG_THR_60]) begin
            w_sel_thr    = r_thr[REG_THR_60];
            w_sel_tenths = TENTHS_6;
        end else if (w_s > r_thr[REG_TOP_THR]) begin
            w_go_mul = 1'b0;
        end
    end

    assign w_thr_ext = HW'(w_sel_thr);
    assign w_acc_ext = DW'(r_acc);

    always_comb begin
        case (r_tenths)
            TENTHS_2: w_dividend = w_acc_ext << 1;
            TENTHS_4: w_dividend = w_acc_ext << 2;
            TENTHS_5: w_dividend = (w_acc_ext << 2) + w_acc_ext;
            TENTHS_6: w_dividend = (w_acc_ext << 2) + (w_acc_ext << 1);
            TENTHS_8: w_dividend = w_acc_ext << 3;
            default:  w_dividend = '0;
        endcase
    end

    assign w_rem2  = {r_rem, r_quo[DUTY_BITS-1]};
    assign w_ge    = (w_rem2 >= {1'b0, r_den});
    assign w_qnext = {r_quo[DUTY_BITS-2:0], w_ge};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_mplier    = r_mplier;
        n_mcand     = r_mcand;
        n_acc       = r_acc;
        n_tenths    = r_tenths;
        n_den       = r_den;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_res_limit = r_res_limit;
        n_res_latch = r_res_latch;
        n_latch     = r_latch;
        n_out_valid = r_out_valid && !out_ch.ready;
        n_out_limit = r_out_limit;
        n_out_latch = r_out_latch;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_latch) begin
                        n_res_limit = '0;
                        n_res_latch = (w_s < r_thr[REG_THR_20]);
                        n_state     = S_DONE;
                    end else if (w_go_mul) begin
                        n_mplier = w_num;
                        n_mcand  = PW'(r_max_duty);
                        n_acc    = '0;
                        n_tenths = w_sel_tenths;
                        n_den    = (w_thr_ext << 3) + (w_thr_ext << 1);
                        n_cnt    = CW'(ADC_BITS);
                        n_state  = S_MUL;
                    end else begin
                        n_res_limit = (w_s <= r_thr[REG_MIN_THR]) ? '0 : r_max_duty;
                        n_res_latch = (n_res_limit == '0);
                        n_state     = S_DONE;
                    end
                end
            end
            S_MUL: begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_rem   = w_dividend[DW-1:DUTY_BITS];
                n_quo   = w_dividend[DUTY_BITS-1:0];
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_den == '0) begin
                    n_res_limit = '0;
                    n_res_latch = 1'b1;
                    n_state     = S_DONE;
                end else if (r_rem >= r_den) begin
                    n_res_limit = '1;
                    n_res_latch = 1'b0;
                    n_state     = S_DONE;
                end else begin
                    n_cnt   = CW'(DUTY_BITS);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = w_ge ? HW'(w_rem2 - {1'b0, r_den}) : w_rem2[HW-1:0];
                n_quo = w_qnext;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_res_limit = w_qnext;
                    n_res_latch = (w_qnext == '0);
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || out_ch.ready) begin
                    n_out_valid = 1'b1;
                    n_out_limit = r_res_limit;
                    n_out_latch = r_res_latch;
                    n_latch     = r_res_latch;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_latch     <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_latch     <= n_latch;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mplier    <= n_mplier;
        r_mcand     <= n_mcand;
        r_acc       <= n_acc;
        r_tenths    <= n_tenths;
        r_den       <= n_den;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_res_limit <= n_res_limit;
        r_res_latch <= n_res_latch;
        r_out_limit <= n_out_limit;
        r_out_latch <= n_out_latch;
    end

endmodule

@@ design/kadl_chk.sv @@
`include "knob_adc_to_duty_limit_top_assert.svh"

module kadl_chk #(
    parameter int DUTY_BITS = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [DUTY_BITS-1:0] i_duty_limit,
    input logic                 i_off_latched,
    input logic                 i_pready
);

    `KADL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_duty_limit) && $stable(i_off_latched), "stalled result changed")

    `KADL_ASSERT_NOW(a_latch_zero, i_clk, i_rst_n, i_out_valid && i_off_latched, i_duty_limit == '0, "off latch with nonzero limit")

    `KADL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "ready right after accept")

    `KADL_ASSERT_NOW(a_pready_high, i_clk, i_rst_n, 1'b1, i_pready, "pready dropped")

endmodule

bind knob_adc_to_duty_limit_top kadl_chk #(
    .DUTY_BITS (DUTY_BITS)
) u_kadl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (in_ch.valid),
    .i_in_ready    (in_ch.ready),
    .i_out_valid   (out_ch.valid),
    .i_out_ready   (out_ch.ready),
    .i_duty_limit  (out_ch.duty_limit),
    .i_off_latched (out_ch.off_latched),
    .i_pready      (o_pready)
);

@@ verif/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kadl_pkg::*;

    localparam int ADC_W          = 12;
    localparam int DUTY_W         = 16;
    localparam int NUM_REGS       = 7;
    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 9;
    localparam int RAND_PER_PHASE = 145;
    localparam int SETTLE_CYCLES  = 45;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ERR_SHOWN      = 10;
    localparam logic [REG_IW-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              off;
    } t_duty_result;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [APB_DW-1:0] pwdata    = '0;
    logic [APB_DW-1:0] o_prdata;
    logic              o_pready;

    kadl_in_if  #(.ADC_BITS(ADC_W))   in_bus ();
    kadl_out_if #(.DUTY_BITS(DUTY_W)) out_bus ();

    knob_adc_to_duty_limit_top #(
        .ADC_BITS  (ADC_W),
        .DUTY_BITS (DUTY_W)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_bus),
        .out_ch    (out_bus),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // shadow of the register file and the limiter state
    logic [DUTY_W-1:0] cfg_reg [NUM_REGS];
    logic              latch_set;
    logic [DUTY_W-1:0] held_duty;

    t_duty_result      expected_duty [$];
    logic [ADC_W-1:0]  pending_samples [$];

    int   err_count   = 0;
    int   gap_left    = 0;
    int   stall_left  = 0;
    int   idle_cycles = 0;
    bit   quiet       = 1'b0;
    logic in_taken    = 1'b0;

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic void flag_error(string what, longint want, longint got);
        if (err_count < ERR_SHOWN) begin
            $display("ERROR %s: expected %0d, got %0d", what, want, got);
        end
        err_count++;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ADC_W-1:0] pick_sample();
        int r;
        int k;
        int s;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return ADC_W'($urandom_range(0, 4095));
        end
        if (r < 75) begin
            // near one of the segment bounds
            k = $urandom_range(REG_MIN_THR, REG_TOP_THR);
            s = int'(cfg_reg[k]) + int'($urandom_range(0, 6)) - 3;
            if (s < 0) begin
                s = 0;
            end
            if (s > 4095) begin
                s = 4095;
            end
            return s[ADC_W-1:0];
        end
        if (r < 90) begin
            return ADC_W'($urandom_range(0, cfg_reg[REG_MIN_THR]));
        end
        return r[0] ? 12'hFFF : 12'h000;
    endfunction

    function automatic logic [DUTY_W-1:0] limit_for(logic [ADC_W-1:0] s);
        longint unsigned num;
        longint unsigned thr;
        longint unsigned den;
        longint unsigned q;
        t_tenths         tenths;
        num = 64'(s);
        if (s <= cfg_reg[REG_MIN_THR]) begin
            return '0;
        end else if (s <= cfg_reg[REG_THR_20]) begin
            num    = 64'(s) - 64'(cfg_reg[REG_MIN_THR]);
            thr    = 64'(cfg_reg[REG_THR_20]);
            tenths = TENTHS_2;
        end else if (s <= cfg_reg[REG_THR_40]) begin
            thr    = 64'(cfg_reg[REG_THR_40]);
            tenths = TENTHS_4;
        end else if (s <= cfg_reg[REG_THR_50]) begin
            thr    = 64'(cfg_reg[REG_THR_50]);
            tenths = TENTHS_5;
        end else if (s <= cfg_reg[REG_THR_60]) begin
            thr    = 64'(cfg_reg[REG_THR_60]);
            tenths = TENTHS_6;
        end else if (s <= cfg_reg[REG_TOP_THR]) begin
            thr    = 64'(cfg_reg[REG_TOP_THR]);
            tenths = TENTHS_8;
        end else begin
            return cfg_reg[REG_MAX_DUTY];
        end
        den = 64'd10 * thr;
        if (den == 0) begin
            return '0;
        end
        q = num * 64'(cfg_reg[REG_MAX_DUTY]) * 64'(tenths) / den;
        return (q > 64'hFFFF) ? 16'hFFFF : q[DUTY_W-1:0];
    endfunction

    function automatic void advance_knob(logic [ADC_W-1:0] s);
        t_duty_result r;
        if (!latch_set) begin
            held_duty = limit_for(s);
            if (held_duty == 0) begin
                latch_set = 1'b1;
            end
        end else if (s >= cfg_reg[REG_THR_20]) begin
            latch_set = 1'b0;
        end
        r.duty = held_duty;
        r.off  = latch_set;
        expected_duty.push_back(r);
    endfunction

    task automatic apb_access(input logic wr, input logic [REG_IW-1:0] idx,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) begin
            @(posedge i_clk);
        end
        rdata = o_prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // upper data bits are random to exercise register masking
    task automatic cfg_write(input logic [REG_IW-1:0] idx, input logic [DUTY_W-1:0] val);
        logic [APB_DW-1:0] wdata;
        logic [APB_DW-1:0] rdata;
        wdata = $urandom;
        if (idx == REG_MAX_DUTY) begin
            wdata[DUTY_W-1:0] = val;
        end else begin
            wdata[ADC_W-1:0] = val[ADC_W-1:0];
        end
        apb_access(1'b1, idx, wdata, rdata);
        if (idx < NUM_REGS) begin
            cfg_reg[idx] = (idx == REG_MAX_DUTY) ? wdata[DUTY_W-1:0]
                                                 : {4'b0, wdata[ADC_W-1:0]};
            apb_access(1'b0, idx, '0, rdata);
            if (rdata !== APB_DW'(cfg_reg[idx])) begin
                flag_error("register readback", cfg_reg[idx], rdata);
            end
        end
    endtask

    task automatic settle();
        while (pending_samples.size() > 0 || in_bus.valid || expected_duty.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!in_bus.valid || in_taken) begin
            if (in_taken) begin
                gap_left = pick_gap();
            end
            if (gap_left > 0) begin
                in_bus.valid <= 1'b0;
                gap_left--;
            end else if (pending_samples.size() > 0) begin
                in_bus.valid      <= 1'b1;
                in_bus.adc_sample <= pending_samples.pop_front();
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // output backpressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_bus.ready <= 1'b0;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_bus.ready <= 1'b0;
            stall_left = pick_gap();
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    // predictor and result monitor
    always @(posedge i_clk) begin
        t_duty_result got;
        t_duty_result want;
        in_taken <= in_bus.valid && in_bus.ready;
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            advance_knob(in_bus.adc_sample);
        end
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got.duty = out_bus.duty_limit;
            got.off  = out_bus.off_latched;
            if (expected_duty.size() == 0) begin
                flag_error("unexpected item, duty_limit", -1, got.duty);
            end else begin
                want = expected_duty.pop_front();
                if (got.duty !== want.duty) begin
                    flag_error("duty_limit", want.duty, got.duty);
                end
                if (got.off !== want.off) begin
                    flag_error("off_latched", want.off, got.off);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (in_bus.valid && in_bus.ready)
                || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [DUTY_W-1:0] v [NUM_REGS];
        int                sorted_thr [$];
        logic [ADC_W-1:0]  directed_samples [$];
        in_bus.valid      = 1'b0;
        in_bus.adc_sample = '0;
        out_bus.ready     = 1'b0;
        cfg_reg[REG_MIN_THR]  = RST_MIN_THR[DUTY_W-1:0];
        cfg_reg[REG_THR_20]   = RST_THR_20[DUTY_W-1:0];
        cfg_reg[REG_THR_40]   = RST_THR_40[DUTY_W-1:0];
        cfg_reg[REG_THR_50]   = RST_THR_50[DUTY_W-1:0];
        cfg_reg[REG_THR_60]   = RST_THR_60[DUTY_W-1:0];
        cfg_reg[REG_TOP_THR]  = RST_TOP_THR[DUTY_W-1:0];
        cfg_reg[REG_MAX_DUTY] = RST_MAX_DUTY[DUTY_W-1:0];
        latch_set = 1'b0;
        held_duty = RST_MAX_DUTY[DUTY_W-1:0];
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: segment edges, latch set, held while low, wake, recompute
        directed_samples = '{12'd4095, 12'd0, 12'd1277, 12'd1278, 12'd481, 12'd1279,
                             12'd2498, 12'd2499, 12'd2641, 12'd2642, 12'd3482, 12'd3483,
                             12'd4087, 12'd4088, 12'd480, 12'd479, 12'd4095, 12'd4095,
                             12'hAAA, 12'h555, 12'd1278};
        pending_samples = directed_samples;
        repeat (RAND_PER_PHASE) pending_samples.push_back(pick_sample());
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            quiet = (ph % 3 == 2);
            case (ph)
                0, 6: begin
                    sorted_thr = {};
                    repeat (6) sorted_thr.push_back($urandom_range(1, 4095));
                    sorted_thr.sort();
                    for (int i = 0; i < 6; i++) begin
                        v[i] = DUTY_W'(sorted_thr[i]);
                    end
                    v[REG_MIN_THR]  = DUTY_W'($urandom_range(0, sorted_thr[0]));
                    v[REG_MAX_DUTY] = DUTY_W'($urandom_range(1, 65535));
                end
                1: v = '{16'd0, 16'd4095, 16'd4095, 16'd4095, 16'd4095, 16'd4095, 16'hFFFF};
                2: v = '{16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF};
                3: v = '{16'd480, 16'd1278, 16'd2498, 16'd2641, 16'd3482, 16'd4087, 16'd0};
                4: begin
                    // thresholds out of order
                    for (int i = 0; i < 6; i++) begin
                        v[i] = DUTY_W'($urandom_range(1, 4095));
                    end
                    v[REG_MIN_THR]  = DUTY_W'($urandom_range(0, 4095));
                    v[REG_MAX_DUTY] = DUTY_W'($urandom_range(0, 65535));
                end
                5: v = '{16'd4095, 16'd2000, 16'd3000, 16'd3500, 16'd4000, 16'd4095, 16'd6000};
                default: begin
                    // tightly packed bounds
                    v[REG_MIN_THR] = DUTY_W'($urandom_range(0, 4000));
                    for (int i = 1; i < 6; i++) begin
                        v[i] = v[i-1] + DUTY_W'($urandom_range(1, 15));
                    end
                    v[REG_MAX_DUTY] = 16'hFFFF;
                end
            endcase
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_write(i[REG_IW-1:0], v[i]);
            end
            if (ph == 4) begin
                cfg_write(REG_SPARE, DUTY_W'($urandom));
            end
            repeat (RAND_PER_PHASE) pending_samples.push_back(pick_sample());
            settle();
        end

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
